// File: sv/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbc_pkg;

  // Cartridge RAM size in bytes and its address width
  localparam int unsigned RamBytes = 32768;
  localparam int unsigned RamAw    = $clog2(RamBytes);

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Configuration register indexes
  localparam logic [1:0] CfgRomMask    = 2'd0;
  localparam logic [1:0] CfgRamMask    = 2'd1;
  localparam logic [1:0] CfgRamPresent = 2'd2;

  // Result target codes
  localparam logic [1:0] TgtRom   = 2'd0;
  localparam logic [1:0] TgtRam   = 2'd1;
  localparam logic [1:0] TgtOpen  = 2'd2;
  localparam logic [1:0] TgtWrite = 2'd3;

  // Bus address map boundaries
  localparam logic [15:0] AddrBankLo  = 16'h2000;
  localparam logic [15:0] AddrHighBnk = 16'h4000;
  localparam logic [15:0] AddrMode    = 16'h6000;
  localparam logic [15:0] AddrRomEnd  = 16'h8000;
  localparam logic [15:0] AddrRamLo   = 16'hA000;
  localparam logic [15:0] AddrRamHi   = 16'hBFFF;

  localparam logic [3:0] RamEnableKey = 4'hA;
  localparam logic [7:0] OpenBus      = 8'hFF;

  // Reset values of the configuration registers
  localparam logic [6:0] RomMaskRst = 7'd127;
  localparam logic [1:0] RamMaskRst = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] rom_address;
    logic [7:0]  read_data;
  } out_t;

  // Classified access handed from front to back
  typedef struct packed {
    logic [1:0]       target;
    logic             ram_we;
    logic [20:0]      rom_address;
    logic [RamAw-1:0] ram_index;
    logic [7:0]       wdata;
  } op_t;

endpackage

`default_nettype wire

// File: sv/cbc_front.sv
// Front end: accepts bus words, holds the bank and config registers, classifies accesses.
// Depends on cbc_pkg.
`default_nettype none

module cbc_front import cbc_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_i,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_index_i,
  input  wire  [6:0] cfg_data_i,
  input  wire        q_full_i,
  output logic       q_push_o,
  output op_t        q_op_o
);

  logic [6:0] rom_mask_q, rom_mask_d;
  logic [1:0] ram_mask_q, ram_mask_d;
  logic       ram_present_q, ram_present_d;
  logic       ram_en_q, ram_en_d;
  logic [4:0] low_bank_q, low_bank_d;
  logic [1:0] high_bank_q, high_bank_d;
  logic       mode_q, mode_d;

  logic        accept;
  logic [15:0] addr;
  logic        in_ram_win;
  logic        ram_usable;
  logic [6:0]  rom_bank;
  logic [1:0]  ram_bank;
  logic [14:0] ram_lin;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;
  assign addr       = in_i.address;
  assign in_ram_win = (addr >= AddrRamLo) && (addr <= AddrRamHi);
  assign ram_usable = ram_en_q && ram_present_q;

  // Map the access onto ROM and RAM banks
  always_comb begin
    if (addr < AddrHighBnk) begin
      rom_bank = mode_q ? {high_bank_q, 5'd0} : 7'd0;
    end else begin
      rom_bank = {high_bank_q, low_bank_q};
    end
    rom_bank = rom_bank & rom_mask_q;
    ram_bank = mode_q ? (high_bank_q & ram_mask_q) : 2'd0;
    ram_lin  = {ram_bank, addr[12:0]};

    q_op_o.rom_address = 21'd0;
    q_op_o.ram_index   = ram_lin[RamAw-1:0];
    q_op_o.wdata       = in_i.write_data;
    q_op_o.ram_we      = 1'b0;
    if (in_i.command) begin
      q_op_o.target = TgtWrite;
      q_op_o.ram_we = in_ram_win && ram_usable;
    end else if (addr < AddrRomEnd) begin
      q_op_o.target      = TgtRom;
      q_op_o.rom_address = {rom_bank, addr[13:0]};
    end else if (in_ram_win && ram_usable) begin
      q_op_o.target = TgtRam;
    end else begin
      q_op_o.target = TgtOpen;
    end
  end

  // Update bank registers on control writes, config registers on the config port
  always_comb begin
    rom_mask_d    = rom_mask_q;
    ram_mask_d    = ram_mask_q;
    ram_present_d = ram_present_q;
    ram_en_d      = ram_en_q;
    low_bank_d    = low_bank_q;
    high_bank_d   = high_bank_q;
    mode_d        = mode_q;
    if (accept && in_i.command) begin
      if (addr < AddrBankLo) begin
        ram_en_d = (in_i.write_data[3:0] == RamEnableKey);
      end else if (addr < AddrHighBnk) begin
        low_bank_d = (in_i.write_data[4:0] == 5'd0) ? 5'd1 : in_i.write_data[4:0];
      end else if (addr < AddrMode) begin
        high_bank_d = in_i.write_data[1:0];
      end else if (addr < AddrRomEnd) begin
        mode_d = in_i.write_data[0];
      end
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRomMask:    rom_mask_d    = cfg_data_i;
        CfgRamMask:    ram_mask_d    = cfg_data_i[1:0];
        CfgRamPresent: ram_present_d = cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q    <= RomMaskRst;
      ram_mask_q    <= RamMaskRst;
      ram_present_q <= 1'b1;
      ram_en_q      <= 1'b0;
      low_bank_q    <= 5'd1;
      high_bank_q   <= 2'd0;
      mode_q        <= 1'b0;
    end else begin
      rom_mask_q    <= rom_mask_d;
      ram_mask_q    <= ram_mask_d;
      ram_present_q <= ram_present_d;
      ram_en_q      <= ram_en_d;
      low_bank_q    <= low_bank_d;
      high_bank_q   <= high_bank_d;
      mode_q        <= mode_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/cbc_queue.sv
// Short queue of classified accesses between front and back.
// Depends on cbc_pkg.
`default_nettype none

module cbc_queue import cbc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  wire  pop_i,
  output logic valid_o,
  output op_t  head_o
);

  op_t            slot_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   count_q;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cbc_back.sv
// Back end: carries out RAM reads and writes and holds the result register.
// Depends on cbc_pkg.
`default_nettype none

module cbc_back import cbc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  q_valid_i,
  input  op_t  q_head_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_o
);

  logic [7:0]  cart_ram [RamBytes];
  logic [7:0]  ram_rd_q;
  logic        out_valid_q;
  logic [1:0]  target_q;
  logic [20:0] rom_addr_q;

  // Take the next word when the result register is free or being drained
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Cartridge RAM: one access per popped word, read data registered
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_head_i.ram_we) begin
        cart_ram[q_head_i.ram_index] <= q_head_i.wdata;
      end
      ram_rd_q <= cart_ram[q_head_i.ram_index];
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      target_q   <= q_head_i.target;
      rom_addr_q <= q_head_i.rom_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_o.target      = target_q;
  assign out_o.rom_address = rom_addr_q;
  assign out_o.read_data   = (target_q == TgtRam) ? ram_rd_q : OpenBus;

endmodule

`default_nettype wire

// File: sv/cartridge_bank_controller.sv
// Top level of the cartridge bank controller: front end, queue and back end.
// Depends on cbc_pkg, cbc_front, cbc_queue and cbc_back.
`default_nettype none

// Bank controller for a game cartridge with banked ROM and up to 32 KiB of banked RAM.
// Each CPU bus word (read or write) yields exactly one result word, in order. Writes
// below 0x8000 set RAM enable, the low and high bank numbers and the banking mode;
// reads there return the physical ROM byte address. Reads and writes at 0xA000-0xBFFF
// reach the cartridge RAM when it is enabled and fitted; all else reads as open bus.
// One bus word is taken per cycle while the queue is not full; a taken word is registered
// first in the two-entry queue, then, after the single-port RAM access, in the result
// register, which holds it until it is taken. Config writes go through a plain
// write port and take effect on the next cycle; issue them only while the block is idle.
module cartridge_bank_controller import cbc_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_t       out_o,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_index_i,
  input  wire  [6:0] cfg_data_i
);

  logic q_full, q_push, q_pop, q_valid;
  op_t  q_push_op, q_head;

  cbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (q_push_op)
  );

  cbc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  cbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: sv/cbc_checker.sv
// Port-level checks for the cartridge bank controller, bound to the top level.
// Depends on cbc_pkg and cartridge_bank_controller.
`default_nettype none

module cbc_checker import cbc_pkg::*; (
  input wire  clk_i,
  input wire  rst_ni,
  input wire  out_valid_o,
  input wire  out_ready_i,
  input out_t out_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed while stalled");

  // Drop any result right after reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.target == TgtWrite |->
      out_o.rom_address == 21'd0 && out_o.read_data == OpenBus)
    else $error("write result carries data");

  a_open_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.target == TgtOpen |->
      out_o.rom_address == 21'd0 && out_o.read_data == OpenBus)
    else $error("open bus result carries data");

  a_ram_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.target == TgtRam |-> out_o.rom_address == 21'd0)
    else $error("RAM result carries a ROM address");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
